FILE: rtl/sit_pkg.sv
// Shared types for the segment intersection test block.
// No dependencies; compiled first.
package sit_pkg;

  // Per-stage advance strobes, handed from the top level to each orientation unit
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

FILE: rtl/sit_if.sv
// Valid/ready channel interfaces for segment pairs and intersection results.
// No dependencies beyond the language; compiled after sit_pkg.
interface sit_in_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] ax0;
  logic [COORD_BITS-1:0] ay0;
  logic [COORD_BITS-1:0] ax1;
  logic [COORD_BITS-1:0] ay1;
  logic [COORD_BITS-1:0] bx0;
  logic [COORD_BITS-1:0] by0;
  logic [COORD_BITS-1:0] bx1;
  logic [COORD_BITS-1:0] by1;

  modport source (output valid, ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, input ready);
  modport sink (input valid, ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, output ready);
endinterface

interface sit_out_if;
  logic valid;
  logic ready;
  logic crosses;

  modport source (output valid, crosses, input ready);
  modport sink (input valid, crosses, output ready);
endinterface

FILE: rtl/segment_intersection_test.sv
// Segment intersection test: decides whether two grid segments cross or touch.
//
// Channels: in_i carries one segment pair per item (ax0..by1, COORD_BITS wide
// each, unsigned); out_o returns one item per pair with crosses = 1 when the
// segments cross strictly, touch at an endpoint, or overlap collinearly.
// Both channels are valid/ready; an item moves when both are high.
//
// Pipeline: four register stages, which are differences, products, product
// difference reduced to sign and zero, then the combine stage that is the
// output register. Throughput: one pair per cycle while the receiver does
// not stall.
//
// Reset clears all stage valid bits; no result is pending afterwards.
// When the receiver stalls, the result holds and each stage holds only while
// the stage after it is full, so bubbles collapse and in_i.ready drops once
// every stage is occupied. Nothing is dropped or repeated.
// Depends on sit_pkg, sit_if and sit_orient.
module segment_intersection_test import sit_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sit_in_if.sink   in_i,
  sit_out_if.source out_o
);

  localparam int NUM_OR = 4;

  stage_en_t en;
  logic      v1_q, v2_q, v3_q, vo_q;
  logic      crosses_q, hit;
  logic [NUM_OR-1:0] box_d, box1_q, box2_q, box3_q;
  logic [NUM_OR-1:0] neg, zero;

  // True when point p lies in the bounding box of e0-e1, bounds included
  function automatic logic in_box(
    input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
    input logic [COORD_BITS-1:0] ex0, input logic [COORD_BITS-1:0] ey0,
    input logic [COORD_BITS-1:0] ex1, input logic [COORD_BITS-1:0] ey1
  );
    logic [COORD_BITS-1:0] xl, xh, yl, yh;
    xl = (ex0 < ex1) ? ex0 : ex1;
    xh = (ex0 < ex1) ? ex1 : ex0;
    yl = (ey0 < ey1) ? ey0 : ey1;
    yh = (ey0 < ey1) ? ey1 : ey0;
    return (px >= xl) && (px <= xh) && (py >= yl) && (py <= yh);
  endfunction

  // Advance each stage when the one after it is empty or moving
  assign en.s3     = !vo_q || out_o.ready;
  assign en.s2     = !v3_q || en.s3;
  assign en.s1     = !v2_q || en.s2;
  assign in_i.ready = !v1_q || en.s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (in_i.ready) v1_q <= in_i.valid;
      if (en.s1) v2_q <= v1_q;
      if (en.s2) v3_q <= v2_q;
      if (en.s3) vo_q <= v3_q;
    end
  end

  // Bounding-box checks, carried alongside the orientation pipeline
  assign box_d[0] = in_box(in_i.bx0, in_i.by0, in_i.ax0, in_i.ay0, in_i.ax1, in_i.ay1);
  assign box_d[1] = in_box(in_i.bx1, in_i.by1, in_i.ax0, in_i.ay0, in_i.ax1, in_i.ay1);
  assign box_d[2] = in_box(in_i.ax0, in_i.ay0, in_i.bx0, in_i.by0, in_i.bx1, in_i.by1);
  assign box_d[3] = in_box(in_i.ax1, in_i.ay1, in_i.bx0, in_i.by0, in_i.bx1, in_i.by1);

  always_ff @(posedge clk_i) begin
    if (in_i.ready) box1_q <= box_d;
    if (en.s1) box2_q <= box1_q;
    if (en.s2) box3_q <= box2_q;
  end

  // Stage-one enables of the units are the input acceptance strobe
  stage_en_t unit_en;
  assign unit_en.s1 = in_i.ready;
  assign unit_en.s2 = en.s1;
  assign unit_en.s3 = en.s2;

  // d1, d2: B's endpoints against line A; d3, d4: A's endpoints against line B
  sit_orient #(.COORD_BITS(COORD_BITS)) u_d1 (
    .clk_i, .en_i(unit_en),
    .px_i(in_i.ax0), .py_i(in_i.ay0), .qx_i(in_i.ax1), .qy_i(in_i.ay1),
    .rx_i(in_i.bx0), .ry_i(in_i.by0), .neg_o(neg[0]), .zero_o(zero[0])
  );
  sit_orient #(.COORD_BITS(COORD_BITS)) u_d2 (
    .clk_i, .en_i(unit_en),
    .px_i(in_i.ax0), .py_i(in_i.ay0), .qx_i(in_i.ax1), .qy_i(in_i.ay1),
    .rx_i(in_i.bx1), .ry_i(in_i.by1), .neg_o(neg[1]), .zero_o(zero[1])
  );
  sit_orient #(.COORD_BITS(COORD_BITS)) u_d3 (
    .clk_i, .en_i(unit_en),
    .px_i(in_i.bx0), .py_i(in_i.by0), .qx_i(in_i.bx1), .qy_i(in_i.by1),
    .rx_i(in_i.ax0), .ry_i(in_i.ay0), .neg_o(neg[2]), .zero_o(zero[2])
  );
  sit_orient #(.COORD_BITS(COORD_BITS)) u_d4 (
    .clk_i, .en_i(unit_en),
    .px_i(in_i.bx0), .py_i(in_i.by0), .qx_i(in_i.bx1), .qy_i(in_i.by1),
    .rx_i(in_i.ax1), .ry_i(in_i.ay1), .neg_o(neg[3]), .zero_o(zero[3])
  );

  // Combine: strict opposite sides on both lines, or a collinear endpoint in the box
  assign hit = (!zero[0] && !zero[1] && (neg[0] != neg[1]) &&
                !zero[2] && !zero[3] && (neg[2] != neg[3])) ||
               |(zero & box3_q);

  always_ff @(posedge clk_i) begin
    if (en.s3) crosses_q <= hit;
  end

  assign out_o.valid   = vo_q;
  assign out_o.crosses = crosses_q;

  // A full stage three that is allowed to move must present a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en.s3) |=> out_o.valid)
    else $error("stage three item lost before output");

  // An accepted item must occupy stage one next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted item not captured");

  // A stalled stage-one item keeps its box checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !en.s1) |=> (v1_q && $stable(box1_q)))
    else $error("stalled stage one changed");

  // Input may only be refused when every stage is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q && vo_q))
    else $error("input refused with a free stage");

endmodule

FILE: rtl/sit_orient.sv
// Three-stage orientation unit: differences, products, sign and zero flags.
// Depends on sit_pkg (stage_en_t).
module sit_orient import sit_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  stage_en_t             en_i,
  input  logic [COORD_BITS-1:0] px_i,
  input  logic [COORD_BITS-1:0] py_i,
  input  logic [COORD_BITS-1:0] qx_i,
  input  logic [COORD_BITS-1:0] qy_i,
  input  logic [COORD_BITS-1:0] rx_i,
  input  logic [COORD_BITS-1:0] ry_i,
  output logic                  neg_o,
  output logic                  zero_o
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [DW-1:0] dqx_q, dry_q, dqy_q, drx_q;
  logic signed [DW-1:0] dqx_d, dry_d, dqy_d, drx_d;
  logic signed [PW-1:0] pa_q, pb_q;
  logic signed [PW:0]   diff;
  logic                 neg_q, zero_q;

  // Form the coordinate differences as signed values one bit wider
  assign dqx_d = $signed({1'b0, qx_i}) - $signed({1'b0, px_i});
  assign dry_d = $signed({1'b0, ry_i}) - $signed({1'b0, py_i});
  assign dqy_d = $signed({1'b0, qy_i}) - $signed({1'b0, py_i});
  assign drx_d = $signed({1'b0, rx_i}) - $signed({1'b0, px_i});

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      dqx_q <= dqx_d;
      dry_q <= dry_d;
      dqy_q <= dqy_d;
      drx_q <= drx_d;
    end
  end

  // Multiply the two cross terms, operands sign-extended to the product width
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      pa_q <= PW'(dqx_q) * PW'(dry_q);
      pb_q <= PW'(dqy_q) * PW'(drx_q);
    end
  end

  // Subtract and keep only sign and zero
  assign diff = {pa_q[PW-1], pa_q} - {pb_q[PW-1], pb_q};

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      neg_q  <= diff[PW];
      zero_q <= (diff == '0);
    end
  end

  assign neg_o  = neg_q;
  assign zero_o = zero_q;

endmodule
